[hdl/tpd_pkg.sv]
package tpd_pkg;

   localparam int TPD_ROW_CHARS = 40;
   localparam int QUEUE_DEPTH   = 2;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;

   localparam logic KIND_CHAR   = 1'b0;
   localparam logic KIND_HEADER = 1'b1;

   // header data byte positions on row 0
   localparam logic [5:0] COL_UNITS    = 6'd0;
   localparam logic [5:0] COL_TENS     = 6'd1;
   localparam logic [5:0] COL_SUBTITLE = 6'd5;
   localparam logic [5:0] COL_CHARSET  = 6'd7;

   localparam logic [3:0] MAGAZINE_ZERO = 4'h8;
   localparam logic [3:0] NIBBLE_BAD    = 4'hf;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [3:0]  magazine;
      logic [4:0]  row;
      logic [5:0]  column;
      logic [11:0] page_code;
      logic [2:0]  charset;
      logic        subtitle_flag;
      logic        hamming_error;
   } tpd_op_type;

   typedef struct packed {
      logic       bad;
      logic [3:0] nibble;
   } unham_type;

   // data at bits 1,3,5,7, protection at bits 0,2,4,6
   function automatic logic [7:0] ham_encode(input logic [3:0] n);
      logic p1, p2, p3, p4;
      p1 = ~(n[0] ^ n[2] ^ n[3]);
      p2 = ~(n[0] ^ n[1] ^ n[3]);
      p3 = ~(n[0] ^ n[1] ^ n[2]);
      p4 = ~(p1 ^ n[0] ^ p2 ^ n[1] ^ p3 ^ n[2] ^ n[3]);
      return {n[3], p4, n[2], p3, n[1], p2, n[0], p1};
   endfunction

   function automatic unham_type unham(input logic [7:0] b);
      unham_type  res;
      logic [7:0] x;
      res.bad    = 1'b1;
      res.nibble = NIBBLE_BAD;
      for (int n = 15; n >= 0; n--) begin
         x = ham_encode(4'(n)) ^ b;
         if ((x & (x - 8'd1)) == 8'd0) begin
            res.bad    = 1'b0;
            res.nibble = 4'(n);
         end
      end
      return res;
   endfunction

   // latin g0 primary set, codes below 0x20 pass through
   function automatic logic [7:0] g0_lookup(input logic [6:0] c);
      logic [7:0] r;
      case (c)
         7'h23:   r = 8'ha3;
         7'h5b:   r = 8'hab;
         7'h5c:   r = 8'hbd;
         7'h5d:   r = 8'hbb;
         7'h5f:   r = 8'h23;
         7'h60:   r = 8'h2d;
         7'h7b:   r = 8'hbc;
         7'h7c:   r = 8'ha6;
         7'h7d:   r = 8'hbe;
         7'h7e:   r = 8'hf7;
         default: r = {1'b0, c};
      endcase
      return r;
   endfunction

endpackage

[hdl/teletext_packet_decoder_top.sv]
// a result is queued as its request is accepted, then moved to the output register
// throughput: one request per cycle while the queue is not full, set by the front decode
// a two-entry queue and an output register part the request and result sides
// reset: synchronous active high, clears queue, output valid and packet state
// after reset the magazine reads 8 and the decoder waits for a packet start
module teletext_packet_decoder_top #(
   parameter int ROW_CHARS = tpd_pkg::TPD_ROW_CHARS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [tpd_pkg::REQ_DATA_W-1:0] req_tdata,  // data_byte
   input  logic                           req_tuser,  // packet_start
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // magazine, row, column, char_code, parity_error, page code, charset,
   // subtitle_flag, hamming_error
   output logic [tpd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser   // kind
);
   import tpd_pkg::*;

   logic       accept;
   logic       push, full, pop, not_empty;
   tpd_op_type push_op, pop_op;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   tpd_front #(
      .ROW_CHARS (ROW_CHARS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_tdata),
      .packet_start (req_tuser),
      .push         (push),
      .push_op      (push_op)
   );

   tpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_op    (pop_op)
   );

   tpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (not_empty),
      .op         (pop_op),
      .op_pop     (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[hdl/tpd_front.sv]
module tpd_front #(
   parameter int ROW_CHARS = tpd_pkg::TPD_ROW_CHARS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 packet_start,
   output logic                 push,
   output tpd_pkg::tpd_op_type  push_op
);
   import tpd_pkg::*;

   localparam int POS_W = $clog2(ROW_CHARS + 2);
   localparam logic [POS_W-1:0] POS_IDLE  = POS_W'(0);
   localparam logic [POS_W-1:0] POS_ADDR1 = POS_W'(1);
   localparam logic [POS_W-1:0] POS_DATA0 = POS_W'(2);
   localparam logic [POS_W-1:0] COL_LAST  = POS_W'(ROW_CHARS - 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       low_ff, low_in;
   logic [3:0]       mag_ff, mag_in;
   logic [4:0]       row_ff, row_in;
   logic [3:0]       units_ff, units_in;
   logic [3:0]       tens_ff, tens_in;
   logic             sub_ff, sub_in;
   logic             seen_ff, seen_in;

   unham_type        ham;
   logic [7:0]       addr;
   logic [POS_W-1:0] col;
   logic [5:0]       column;

   assign ham    = unham(data_byte);
   assign addr   = {ham.nibble, low_ff};
   assign col    = pos_ff - POS_DATA0;
   assign column = 6'(col);

   always_comb begin
      pos_in   = pos_ff;
      low_in   = low_ff;
      mag_in   = mag_ff;
      row_in   = row_ff;
      units_in = units_ff;
      tens_in  = tens_ff;
      sub_in   = sub_ff;
      seen_in  = seen_ff;
      push     = 1'b0;
      push_op  = '0;
      push_op.kind          = KIND_CHAR;
      push_op.data_byte     = data_byte;
      push_op.magazine      = mag_ff;
      push_op.row           = row_ff;
      push_op.column        = column;
      push_op.hamming_error = seen_ff;
      if (accept) begin
         if (packet_start) begin
            seen_in = ham.bad;
            low_in  = ham.nibble;
            pos_in  = POS_ADDR1;
         end else if (pos_ff == POS_IDLE) begin
            pos_in = POS_IDLE;
         end else if (pos_ff == POS_ADDR1) begin
            mag_in  = (addr[2:0] == 3'd0) ? MAGAZINE_ZERO : {1'b0, addr[2:0]};
            row_in  = addr[7:3];
            seen_in = seen_ff | ham.bad;
            pos_in  = POS_DATA0;
         end else begin
            pos_in = (col == COL_LAST) ? POS_IDLE : pos_ff + POS_W'(1);
            if (row_ff == 5'd0) begin
               case (column)
                  COL_UNITS: begin
                     units_in = ham.nibble;
                     seen_in  = seen_ff | ham.bad;
                  end
                  COL_TENS: begin
                     tens_in = ham.nibble;
                     seen_in = seen_ff | ham.bad;
                  end
                  COL_SUBTITLE: begin
                     sub_in  = ham.nibble[3];
                     seen_in = seen_ff | ham.bad;
                  end
                  COL_CHARSET: begin
                     seen_in               = seen_ff | ham.bad;
                     push                  = 1'b1;
                     push_op.kind          = KIND_HEADER;
                     push_op.page_code     = {mag_ff, tens_ff, units_ff};
                     push_op.charset       = ham.nibble[3:1];
                     push_op.subtitle_flag = sub_ff;
                     push_op.hamming_error = seen_ff | ham.bad;
                  end
                  default: begin
                     push = 1'b0;
                  end
               endcase
            end else begin
               push = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_IDLE;
         low_ff   <= 4'd0;
         mag_ff   <= MAGAZINE_ZERO;
         row_ff   <= 5'd0;
         units_ff <= 4'd0;
         tens_ff  <= 4'd0;
         sub_ff   <= 1'b0;
         seen_ff  <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         low_ff   <= low_in;
         mag_ff   <= mag_in;
         row_ff   <= row_in;
         units_ff <= units_in;
         tens_ff  <= tens_in;
         sub_ff   <= sub_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

[hdl/tpd_queue.sv]
module tpd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tpd_pkg::tpd_op_type  push_op,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output tpd_pkg::tpd_op_type  pop_op
);
   import tpd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   tpd_op_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != CNT_W'(0));
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_op    = entry_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? PTR_W'(0) : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? PTR_W'(0) : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ff] <= push_op;
      end
   end

endmodule

[hdl/tpd_back.sv]
module tpd_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           op_valid,
   input  tpd_pkg::tpd_op_type            op,
   output logic                           op_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tpd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser
);
   import tpd_pkg::*;

   logic                  valid_ff;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   logic                  kind_ff;
   logic [7:0]            char_code;
   logic                  parity_error;

   assign op_pop = op_valid && (!valid_ff || rsp_tready);

   always_comb begin
      char_code    = 8'd0;
      parity_error = 1'b0;
      if (op.kind == KIND_CHAR) begin
         if (!(^op.data_byte)) begin
            char_code    = CHAR_SPACE;
            parity_error = 1'b1;
         end else begin
            char_code = g0_lookup(op.data_byte[6:0]);
         end
      end
      data_in = {7'd0, op.hamming_error, op.subtitle_flag, op.charset, op.page_code,
                 parity_error, char_code, op.column, op.row, op.magazine};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (op_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
      if (op_pop) begin
         data_ff <= data_in;
         kind_ff <= op.kind;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;

endmodule

[hdl/tpd_checker.sv]
module tpd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tpd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);
   import tpd_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("result valid or request side blocked after reset");

   // header only on row 0 after data byte 7
   a_header_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_HEADER) |->
         rsp_tdata[8:4] == 5'd0 && rsp_tdata[14:9] == COL_CHARSET &&
         rsp_tdata[22:15] == 8'd0 && !rsp_tdata[23])
      else $error("bad header result");

   a_char_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_CHAR) |->
         rsp_tdata[39:24] == 16'd0 && rsp_tdata[8:4] != 5'd0)
      else $error("bad character result");

   a_parity_space: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23] |-> rsp_tdata[22:15] == CHAR_SPACE &&
         rsp_tdata[3:0] != 4'd0)
      else $error("parity error without space");

endmodule

bind teletext_packet_decoder_top tpd_checker u_tpd_checker (.*);

[sim/testbench.sv]
module testbench;

   localparam int ROW_CHARS  = tpd_pkg::TPD_ROW_CHARS;
   localparam int ITEMS      = 1150;
   localparam int IDLE_LIMIT = 3000;
   localparam int LONG_HOLD  = 300;

   typedef struct packed {
      logic        kind;
      logic [3:0]  magazine;
      logic [4:0]  row;
      logic [5:0]  column;
      logic [7:0]  char_code;
      logic        parity_error;
      logic [11:0] page_code;
      logic [2:0]  charset;
      logic        subtitle_flag;
      logic        hamming_error;
   } tt_result_type;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [tpd_pkg::REQ_DATA_W-1:0] req_tdata  = '0;  // data_byte
   logic                           req_tuser  = 1'b0; // packet_start
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // magazine, row, column, char_code, parity_error, page code, charset,
   // subtitle_flag, hamming_error
   logic [tpd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;         // kind

   logic hold_go = 1'b0;
   int   burst_left = 0;
   int   idle_cycles = 0;

   // hamming 8/4 code word: data at odd bits, protection at even bits
   function automatic logic [7:0] hamming_word(input logic [3:0] d);
      logic [7:0] w;
      w    = 8'h00;
      w[1] = d[0];
      w[3] = d[1];
      w[5] = d[2];
      w[7] = d[3];
      w[0] = ~^{d[0], d[2], d[3]};
      w[2] = ~^{d[0], d[1], d[3]};
      w[4] = ~^{d[0], d[1], d[2]};
      w[6] = ~^{w[7], w[5:0]};
      return w;
   endfunction

   class page_char_scoreboard;
      logic [6:0] position   = '0;
      logic [3:0] addr_low   = '0;
      logic [3:0] mag        = tpd_pkg::MAGAZINE_ZERO;
      logic [4:0] row        = '0;
      logic [3:0] units      = '0;
      logic [3:0] tens       = '0;
      logic       subtitle   = 1'b0;
      logic       ham_seen   = 1'b0;
      tt_result_type due_results[$];
      int unsigned mismatches = 0;

      function logic [3:0] decode_nibble(logic [7:0] b);
         for (int n = 0; n < 16; n++) begin
            if ($countones(hamming_word(4'(n)) ^ b) <= 1) return 4'(n);
         end
         ham_seen = 1'b1;
         return tpd_pkg::NIBBLE_BAD;
      endfunction

      function logic [7:0] g0_char(logic [6:0] c);
         case (c)
            7'h23:   return 8'ha3;
            7'h5b:   return 8'hab;
            7'h5c:   return 8'hbd;
            7'h5d:   return 8'hbb;
            7'h5f:   return 8'h23;
            7'h60:   return 8'h2d;
            7'h7b:   return 8'hbc;
            7'h7c:   return 8'ha6;
            7'h7d:   return 8'hbe;
            7'h7e:   return 8'hf7;
            default: return {1'b0, c};
         endcase
      endfunction

      function void note_byte(logic [7:0] b, logic start);
         tt_result_type r;
         logic [5:0] col;
         logic [7:0] addr;
         logic [3:0] n;
         if (start) begin
            ham_seen = 1'b0;
            addr_low = decode_nibble(b);
            position = 7'd1;
            return;
         end
         if (position == 7'd0) return;
         if (position == 7'd1) begin
            addr     = {decode_nibble(b), addr_low};
            mag      = (addr[2:0] == 3'd0) ? tpd_pkg::MAGAZINE_ZERO : {1'b0, addr[2:0]};
            row      = addr[7:3];
            position = 7'd2;
            return;
         end
         col      = 6'(position - 7'd2);
         position = (col + 1 >= ROW_CHARS) ? 7'd0 : position + 7'd1;
         r          = '0;
         r.magazine = mag;
         r.row      = row;
         r.column   = col;
         if (row == 5'd0) begin
            case (col)
               tpd_pkg::COL_UNITS:    units = decode_nibble(b);
               tpd_pkg::COL_TENS:     tens = decode_nibble(b);
               tpd_pkg::COL_SUBTITLE: begin
                  n        = decode_nibble(b);
                  subtitle = n[3];
               end
               tpd_pkg::COL_CHARSET:  begin
                  n               = decode_nibble(b);
                  r.kind          = tpd_pkg::KIND_HEADER;
                  r.page_code     = {mag, tens, units};
                  r.charset       = n[3:1];
                  r.subtitle_flag = subtitle;
                  r.hamming_error = ham_seen;
                  due_results.push_back(r);
               end
               default: ;
            endcase
            return;
         end
         r.kind = tpd_pkg::KIND_CHAR;
         if (^b == 1'b0) begin
            r.char_code    = tpd_pkg::CHAR_SPACE;
            r.parity_error = 1'b1;
         end else begin
            r.char_code = g0_char(b[6:0]);
         end
         r.hamming_error = ham_seen;
         due_results.push_back(r);
      endfunction

      function string show(tt_result_type r);
         return {$sformatf("kind %0d mag %0d row %0d col %0d char %02h par %0d ",
                           r.kind, r.magazine, r.row, r.column, r.char_code,
                           r.parity_error),
                 $sformatf("page %03h cs %0d sub %0d ham %0d",
                           r.page_code, r.charset, r.subtitle_flag, r.hamming_error)};
      endfunction

      function void note_mismatch(string what);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", what);
      endfunction

      function void check_result(logic [tpd_pkg::RSP_DATA_W-1:0] d, logic u);
         tt_result_type got, want;
         got.kind          = u;
         got.magazine      = d[3:0];
         got.row           = d[8:4];
         got.column        = d[14:9];
         got.char_code     = d[22:15];
         got.parity_error  = d[23];
         got.page_code     = d[35:24];
         got.charset       = d[38:36];
         got.subtitle_flag = d[39];
         got.hamming_error = d[40];
         if (due_results.size() == 0) begin
            note_mismatch({"unexpected ", show(got)});
            return;
         end
         want = due_results.pop_front();
         if (got !== want) note_mismatch({"expected ", show(want), " got ", show(got)});
      endfunction
   endclass

   page_char_scoreboard sb = new();

   teletext_packet_decoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int  mode;
      int  mode_left;
      bit  held;
      mode      = 0;
      mode_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic s);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.due_results.size() != 0) @(posedge clock);
   endtask

   // code word, now and then with a single-bit error or replaced by noise
   function automatic logic [7:0] coded_nibble(input logic [3:0] n);
      logic [7:0] w;
      int         pick;
      w    = hamming_word(n);
      pick = $urandom_range(0, 19);
      if (pick < 2) w = w ^ (8'h01 << $urandom_range(0, 7));
      else if (pick == 2) w = 8'($urandom);
      return w;
   endfunction

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if ($urandom_range(0, 99) < 85) b[7] = ~^b[6:0];
      return b;
   endfunction

   task automatic send_packet(input logic [2:0] mag, input logic [4:0] row, input int len);
      logic [7:0] addr;
      logic [7:0] b;
      addr = {row, mag};
      send_byte(coded_nibble(addr[3:0]), 1'b1);
      send_byte(coded_nibble(addr[7:4]), 1'b0);
      for (int col = 0; col < len; col++) begin
         if (row != 5'd0) b = text_byte();
         else if (col == 0 || col == 1 || col == 5 || col == 7) b = coded_nibble(4'($urandom));
         else b = 8'($urandom);
         send_byte(b, 1'b0);
      end
   endtask

   initial begin
      int sent;
      int pick;
      int n;
      bit drained_mid;
      logic [4:0] pkt_row;
      sent        = 0;
      drained_mid = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // stray byte, then a truncated row-0 header on magazine 0
      send_byte(8'hff, 1'b0);
      send_byte(hamming_word(4'h0), 1'b1);
      send_byte(hamming_word(4'h0), 1'b0);
      send_byte(hamming_word(4'h9), 1'b0);
      send_byte(hamming_word(4'h9) ^ 8'h10, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(hamming_word(4'h8), 1'b0);
      send_byte(8'haa, 1'b0);
      send_byte(hamming_word(4'hf), 1'b0);
      // restart mid packet with an uncorrectable address byte: magazine 7, row 31
      send_byte(hamming_word(4'h7) ^ 8'h03, 1'b1);
      send_byte(hamming_word(4'hf), 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7f, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h23, 1'b0);
      send_byte(8'hdc, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h1f, 1'b0);
      send_byte(8'he0, 1'b0);
      sent = 22;
      wait_drained();

      while (sent < ITEMS) begin
         if (!drained_mid && sent >= 350) begin
            wait_drained();
            drained_mid = 1'b1;
         end
         if (!hold_go && sent >= 600) hold_go = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ROW_CHARS - 1) : ROW_CHARS;
            pkt_row = ($urandom_range(0, 4) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
            send_packet(3'($urandom), pkt_row, n);
            sent += n + 2;
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
         end else begin
            n = $urandom_range(0, 5);
            send_byte(8'($urandom), 1'b1);
            repeat (n) send_byte(8'($urandom), 1'b0);
            sent += n + 1;
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[files.f]
hdl/tpd_pkg.sv
hdl/tpd_front.sv
hdl/tpd_queue.sv
hdl/tpd_back.sv
hdl/teletext_packet_decoder_top.sv
hdl/tpd_checker.sv
sim/testbench.sv
